// ----- hdl/ors_pkg.sv -----
// ----------------------------------------------------------------------------
// ors_pkg
// Shared types and constants of the 1-Wire ROM search decision engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ors_pkg;

  typedef enum logic [1:0] {
    CMD_NEW    = 2'd0,
    CMD_PASS   = 2'd1,
    CMD_PAIR   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  localparam int          ROM_W            = 64;
  localparam int          CNT_W            = 8;
  localparam int          CMD_BITS         = 8;
  localparam int          BEAT_W           = $clog2(CMD_BITS);
  localparam logic [7:0]  SEARCH_CMD_RESET = 8'hF0;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic                 burst;
    logic [CMD_BITS-1:0]  cmd_byte;
    logic                 write_bit;
    logic                 write_valid;
    logic [ROM_W-1:0]     found_rom;
    logic                 rom_valid;
    logic                 search_done;
    logic                 no_device;
    logic                 read_error;
    logic [CNT_W-1:0]     device_count;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/ors_if.sv -----
// ----------------------------------------------------------------------------
// ors_if
// Request channels of the ROM search engine: input, result and config.
// ----------------------------------------------------------------------------
`default_nettype none

interface ors_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       device_present;
  logic       bit_a;
  logic       bit_b;

  modport source (output valid, cmd, device_present, bit_a, bit_b, input ready);
  modport sink   (input valid, cmd, device_present, bit_a, bit_b, output ready);
endinterface

interface ors_out_if;
  logic        valid;
  logic        ready;
  logic        write_bit;
  logic        write_valid;
  logic        last;
  logic [63:0] found_rom;
  logic        rom_valid;
  logic        search_done;
  logic        no_device;
  logic        read_error;
  logic [7:0]  device_count;

  modport source (output valid, write_bit, write_valid, last, found_rom, rom_valid,
                  search_done, no_device, read_error, device_count, input ready);
  modport sink   (input valid, write_bit, write_valid, last, found_rom, rom_valid,
                  search_done, no_device, read_error, device_count, output ready);
endinterface

interface ors_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] search_command;

  modport source (output valid, search_command, input ready);
  modport sink   (input valid, search_command, output ready);
endinterface

`default_nettype wire

// ----- hdl/ors_core.sv -----
// ----------------------------------------------------------------------------
// ors_core
// Input register, search state and the per-request direction decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_core
  import ors_pkg::*;
#(
  parameter int ROM_BITS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ors_in_if.sink             in_ch,
  input  wire logic [7:0]    search_command,
  output logic               res_valid,
  output res_t               res,
  input  wire logic          res_ready
);

  localparam int PW = $clog2(ROM_BITS + 2);
  localparam int IW = $clog2(ROM_BITS);
  localparam logic [PW-1:0] POS_FIRST = PW'(1);
  localparam logic [PW-1:0] POS_LAST  = PW'(ROM_BITS);
  localparam logic [PW-1:0] POS_IDLE  = PW'(ROM_BITS + 1);

  logic                in_vld_r;
  cmd_t                cmd_r;
  logic                present_r;
  logic                a_r;
  logic                b_r;

  logic [ROM_BITS-1:0] code_r, code_nxt;
  logic [PW-1:0]       ld_r, ld_nxt;
  logic [PW-1:0]       nm_r, nm_nxt;
  logic [PW-1:0]       bp_r, bp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                fin_r, fin_nxt;

  logic                has_res;
  logic                dir_bit;
  logic                advance;
  logic                accept;
  logic                in_pass;
  logic [PW-1:0]       pos_m1;
  logic [IW-1:0]       idx;

  assign pos_m1  = bp_r - POS_FIRST;
  assign idx     = pos_m1[IW-1:0];
  assign in_pass = (bp_r >= POS_FIRST) && (bp_r <= POS_LAST);

  always_comb begin
    code_nxt = code_r;
    ld_nxt   = ld_r;
    nm_nxt   = nm_r;
    bp_nxt   = bp_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    has_res  = 1'b0;
    dir_bit  = 1'b0;
    res      = '0;
    if (in_vld_r) begin
      unique case (cmd_r)
        CMD_NEW: begin
          code_nxt = '0;
          ld_nxt   = '0;
          nm_nxt   = '0;
          bp_nxt   = POS_FIRST;
          cnt_nxt  = '0;
          fin_nxt  = 1'b0;
        end
        CMD_PASS: begin
          has_res = 1'b1;
          if (fin_r) begin
            // finished search, status only
          end else if (!present_r) begin
            cnt_nxt       = '0;
            fin_nxt       = 1'b1;
            bp_nxt        = POS_IDLE;
            res.no_device = 1'b1;
          end else begin
            bp_nxt          = POS_FIRST;
            nm_nxt          = '0;
            res.burst       = 1'b1;
            res.cmd_byte    = search_command;
            res.write_valid = 1'b1;
          end
        end
        CMD_PAIR: begin
          if (!fin_r && in_pass) begin
            has_res = 1'b1;
            if (a_r && b_r) begin
              ld_nxt         = '0;
              nm_nxt         = '0;
              fin_nxt        = 1'b1;
              bp_nxt         = POS_IDLE;
              res.read_error = 1'b1;
            end else begin
              if (a_r || b_r) begin
                dir_bit = a_r;
              end else if (bp_r == ld_r) begin
                dir_bit = 1'b1;
              end else if (bp_r > ld_r) begin
                dir_bit = 1'b0;
                nm_nxt  = bp_r;
              end else begin
                dir_bit = code_r[idx];
                if (!dir_bit) begin
                  nm_nxt = bp_r;
                end
              end
              code_nxt[idx] = dir_bit;
              if (bp_r == POS_LAST) begin
                ld_nxt        = nm_nxt;
                cnt_nxt       = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
                fin_nxt       = (nm_nxt == '0);
                bp_nxt        = POS_IDLE;
                res.found_rom = ROM_W'(code_nxt);
                res.rom_valid = 1'b1;
              end else begin
                bp_nxt = bp_r + 1'b1;
              end
              res.write_bit   = dir_bit;
              res.write_valid = 1'b1;
            end
          end
        end
        CMD_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
    res.search_done  = fin_nxt;
    res.device_count = cnt_nxt;
  end

  assign res_valid   = in_vld_r && has_res;
  assign advance     = in_vld_r && (!has_res || res_ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      code_r   <= '0;
      ld_r     <= '0;
      nm_r     <= '0;
      bp_r     <= POS_FIRST;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
    end else begin
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        code_r <= code_nxt;
        ld_r   <= ld_nxt;
        nm_r   <= nm_nxt;
        bp_r   <= bp_nxt;
        cnt_r  <= cnt_nxt;
        fin_r  <= fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= cmd_t'(in_ch.cmd);
      present_r <= in_ch.device_present;
      a_r       <= in_ch.bit_a;
      b_r       <= in_ch.bit_b;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ors_emit.sv -----
// ----------------------------------------------------------------------------
// ors_emit
// Result register; plays a pass start out as eight command-bit results.
// ----------------------------------------------------------------------------
`default_nettype none

module ors_emit
  import ors_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  wire res_t res,
  output logic      res_ready,
  ors_out_if.source out_ch
);

  logic              vld_r;
  res_t              res_r;
  logic [BEAT_W-1:0] beat_r;
  logic              out_last;

  assign out_last  = !res_r.burst || (beat_r == BEAT_W'(CMD_BITS - 1));
  assign res_ready = !vld_r || (out_ch.ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= '0;
    end else if (res_ready) begin
      vld_r  <= res_valid;
      beat_r <= '0;
    end else if (out_ch.ready) begin
      beat_r <= beat_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.write_bit    = res_r.burst ? res_r.cmd_byte[beat_r] : res_r.write_bit;
  assign out_ch.write_valid  = res_r.write_valid;
  assign out_ch.last         = out_last;
  assign out_ch.found_rom    = res_r.found_rom;
  assign out_ch.rom_valid    = res_r.rom_valid;
  assign out_ch.search_done  = res_r.search_done;
  assign out_ch.no_device    = res_r.no_device;
  assign out_ch.read_error   = res_r.read_error;
  assign out_ch.device_count = res_r.device_count;

endmodule

`default_nettype wire

// ----- hdl/onewire_rom_search.sv -----
// ----------------------------------------------------------------------------
// onewire_rom_search
// Decision engine of a 1-Wire ROM search master.
// ----------------------------------------------------------------------------
// path: core input register, then the result register of the emitter
// throughput: one request per cycle unless results stall; a pass start holds
//   the result register; its eight command bits go out one per ready cycle
// reset: synchronous active low; state as after a new search, command 0xF0
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search
  import ors_pkg::*;
#(
  parameter int ROM_BITS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ors_in_if.sink    in_ch,
  ors_out_if.source out_ch,
  ors_cfg_if.sink   cfg_ch
);

  logic       cfg_wr;
  logic [7:0] search_cmd_q_r;
  logic       res_valid;
  logic       res_ready;
  res_t       res;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_cmd_q_r <= SEARCH_CMD_RESET;
    end else if (cfg_wr) begin
      search_cmd_q_r <= cfg_ch.search_command;
    end
  end

  ors_core #(
    .ROM_BITS(ROM_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .search_command(search_cmd_q_r),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  ors_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready),
    .out_ch   (out_ch)
  );

  a_rom_closes_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rom_valid |-> out_ch.write_valid && out_ch.last)
    else $error("rom report without final write bit");

  a_abort_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.read_error || out_ch.no_device)
      |-> out_ch.search_done && !out_ch.write_valid && out_ch.last)
    else $error("abort result malformed");

  a_idle_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ----- bench/tb_onewire_rom_search.sv -----
// ----------------------------------------------------------------------------
// tb_onewire_rom_search
// Self-checking bench for the 1-Wire ROM search decision engine. Requests go
// in through the input channel; an in-bench model of the tree walk predicts
// every result, and a checker compares each one, field by field, with the
// oldest prediction. Directed cases come first. Random traffic follows,
// mostly full searches over small simulated device sets on a wired-AND bus,
// mixed with broken passes and noise. A short run of all-conflict passes
// keeps the search open while the device count climbs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_onewire_rom_search
  import ors_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ROM_BITS      = 64;
  localparam real         CLK_PERIOD    = 2.0;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct {
    logic        write_bit;
    logic        write_valid;
    logic        last;
    logic [63:0] found_rom;
    logic        rom_valid;
    logic        search_done;
    logic        no_device;
    logic        read_error;
    logic [7:0]  device_count;
  } search_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  ors_in_if  in_ch ();
  ors_out_if out_ch ();
  ors_cfg_if cfg_ch ();

  onewire_rom_search #(
    .ROM_BITS (ROM_BITS)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // tree walk state
  logic [7:0]  command_byte;
  logic [63:0] walk_code;
  logic [6:0]  disc_last;
  logic [6:0]  disc_new;
  logic [6:0]  rom_pos;
  logic [7:0]  found_roms;
  logic        search_over;
  bit          steered_bit;

  search_reply_t pending_replies[$];
  int unsigned   sent_requests = 0;
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   src_gap_pct = 30;
  int unsigned   sink_stall_pct = 62;

  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  function automatic void clear_walk();
    walk_code   = '0;
    disc_last   = '0;
    disc_new    = '0;
    rom_pos     = 7'd1;
    found_roms  = '0;
    search_over = 1'b0;
  endfunction

  function automatic search_reply_t blank_reply();
    search_reply_t r;
    r              = '{default: '0};
    r.search_done  = search_over;
    r.device_count = found_roms;
    return r;
  endfunction

  function automatic void walk_rom_tree(cmd_t c, bit present, bit a, bit b);
    search_reply_t r;
    logic [63:0]   mask;
    bit            dir;
    case (c)
      CMD_NEW: begin
        clear_walk();
      end
      CMD_PASS: begin
        if (search_over) begin
          r      = blank_reply();
          r.last = 1'b1;
          pending_replies.push_back(r);
        end else if (!present) begin
          found_roms  = '0;
          search_over = 1'b1;
          rom_pos     = 7'(ROM_BITS + 1);
          r           = blank_reply();
          r.no_device = 1'b1;
          r.last      = 1'b1;
          pending_replies.push_back(r);
        end else begin
          rom_pos  = 7'd1;
          disc_new = '0;
          for (int n = 0; n < 8; n++) begin
            r             = blank_reply();
            r.write_bit   = command_byte[n];
            r.write_valid = 1'b1;
            r.last        = (n == 7);
            pending_replies.push_back(r);
          end
        end
      end
      CMD_PAIR: begin
        if (!search_over && rom_pos >= 1 && rom_pos <= ROM_BITS) begin
          if (a && b) begin
            disc_last   = '0;
            disc_new    = '0;
            search_over = 1'b1;
            rom_pos     = 7'(ROM_BITS + 1);
            r            = blank_reply();
            r.read_error = 1'b1;
            r.last       = 1'b1;
            pending_replies.push_back(r);
          end else begin
            mask = 64'd1 << (rom_pos - 1);
            if (a || b) begin
              dir = a;
            end else if (rom_pos == disc_last) begin
              dir = 1'b1;
            end else if (rom_pos > disc_last) begin
              dir      = 1'b0;
              disc_new = rom_pos;
            end else begin
              dir = (walk_code & mask) != 0;
              if (!dir) disc_new = rom_pos;
            end
            walk_code = dir ? (walk_code | mask) : (walk_code & ~mask);
            if (rom_pos == ROM_BITS) begin
              disc_last = disc_new;
              if (found_roms != 8'hFF) found_roms++;
              search_over = (disc_last == 0);
              rom_pos     = 7'(ROM_BITS + 1);
              r           = blank_reply();
              r.found_rom = walk_code;
              r.rom_valid = 1'b1;
            end else begin
              rom_pos++;
              r = blank_reply();
            end
            r.write_bit   = dir;
            r.write_valid = 1'b1;
            r.last        = 1'b1;
            steered_bit   = dir;
            pending_replies.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // result side: random stalls and checking
  function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_reply();
    search_reply_t exp;
    if (pending_replies.size() == 0) begin
      $error("result with no request pending");
      mismatches++;
    end else begin
      exp = pending_replies.pop_front();
      match_field("write_bit", 64'(exp.write_bit), 64'(out_ch.write_bit));
      match_field("write_valid", 64'(exp.write_valid), 64'(out_ch.write_valid));
      match_field("last", 64'(exp.last), 64'(out_ch.last));
      match_field("found_rom", exp.found_rom, out_ch.found_rom);
      match_field("rom_valid", 64'(exp.rom_valid), 64'(out_ch.rom_valid));
      match_field("search_done", 64'(exp.search_done), 64'(out_ch.search_done));
      match_field("no_device", 64'(exp.no_device), 64'(out_ch.no_device));
      match_field("read_error", 64'(exp.read_error), 64'(out_ch.read_error));
      match_field("device_count", 64'(exp.device_count), 64'(out_ch.device_count));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (out_ch.valid && out_ch.ready) check_reply();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // request side
  task automatic send_request(cmd_t c, bit present, bit a, bit b);
    if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= c;
    in_ch.device_present <= present;
    in_ch.bit_a          <= a;
    in_ch.bit_b          <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_requests++;
    walk_rom_tree(c, present, a, b);
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_search_command(logic [7:0] value);
    wait_quiet();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.search_command <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    command_byte = value;
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n) begin
      send_request(cmd_t'($urandom_range(3)), coin(), coin(), coin());
    end
  endtask

  // full search over simulated devices on a wired-and bus
  task automatic run_bus_search(int unsigned n_dev, int unsigned stop_at);
    logic [63:0] roms[$];
    bit          alive[$];
    logic [63:0] code;
    int unsigned passes;
    int unsigned break_at;
    bit          a, b, aborted;
    for (int i = 0; i < n_dev; i++) begin
      if (i != 0 && $urandom_range(1)) begin
        code = roms[$urandom_range(i - 1)];
        repeat ($urandom_range(1, 3)) code[$urandom_range(63)] ^= 1'b1;
      end else begin
        code = {$urandom, $urandom};
      end
      roms.push_back(code);
      alive.push_back(1'b1);
    end
    send_request(CMD_NEW, coin(), coin(), coin());
    passes = 0;
    while (!search_over && passes < n_dev + 3 && sent_requests < stop_at) begin
      send_request(CMD_PASS, 1'b1, coin(), coin());
      foreach (alive[i]) alive[i] = 1'b1;
      break_at = ($urandom_range(9) == 0) ? $urandom_range(1, ROM_BITS) : 0;
      aborted  = 1'b0;
      for (int pos = 1; pos <= ROM_BITS && !aborted && sent_requests < stop_at; pos++) begin
        if (pos == break_at) begin
          // broken pass: bus fault or restart
          aborted = 1'b1;
          if ($urandom_range(1)) send_request(CMD_PAIR, coin(), 1'b1, 1'b1);
        end else begin
          a = 1'b1;
          b = 1'b1;
          foreach (roms[i]) begin
            if (alive[i]) begin
              if (roms[i][pos-1]) b = 1'b0;
              else a = 1'b0;
            end
          end
          send_request(CMD_PAIR, coin(), a, b);
          foreach (roms[i]) if (roms[i][pos-1] != steered_bit) alive[i] = 1'b0;
        end
      end
      if (!aborted && $urandom_range(4) == 0) begin
        send_request(CMD_PAIR, coin(), coin(), 1'b0);
      end
      passes++;
    end
    if ($urandom_range(1)) begin
      send_request(CMD_PASS, coin(), coin(), coin());
    end
  endtask

  // tests
  task automatic test_reset_defaults();
    send_request(CMD_PAIR, 1'b0, 1'b1, 1'b0);
    send_request(CMD_PAIR, 1'b1, 1'b0, 1'b1);
    send_request(CMD_PAIR, 1'b0, 1'b0, 1'b0);
    send_request(CMD_UNUSED, 1'b1, 1'b1, 1'b1);
    send_request(CMD_PASS, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_read_error();
    send_request(CMD_PAIR, 1'b0, 1'b1, 1'b1);
    send_request(CMD_PAIR, 1'b0, 1'b0, 1'b1);
    send_request(CMD_PASS, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_no_device();
    send_request(CMD_NEW, 1'b0, 1'b0, 1'b0);
    send_request(CMD_PASS, 1'b0, 1'b1, 1'b1);
    send_request(CMD_PASS, 1'b1, 1'b0, 1'b0);
    send_request(CMD_NEW, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_command_extremes();
    write_search_command(8'h00);
    send_request(CMD_PASS, 1'b1, 1'b0, 1'b0);
    write_search_command(8'hFF);
    send_request(CMD_PASS, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                     int unsigned n, logic [7:0] cmd_value);
    int unsigned stop_at;
    int unsigned pick;
    write_search_command(cmd_value);
    src_gap_pct    = src_pct;
    sink_stall_pct = sink_pct;
    stop_at        = sent_requests + n;
    while (sent_requests < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        run_bus_search($urandom_range(1, 3), stop_at);
      end else if (pick < 80) begin
        send_request(CMD_NEW, coin(), coin(), coin());
        send_request(CMD_PASS, 1'b0, coin(), coin());
        send_noise($urandom_range(0, 3));
      end else begin
        send_noise($urandom_range(3, 12));
      end
    end
  endtask

  task automatic test_count_climb();
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    write_search_command(8'($urandom));
    send_request(CMD_NEW, 1'b0, 1'b0, 1'b0);
    // all-conflict passes never finish, so the count keeps climbing
    repeat (2) begin
      send_request(CMD_PASS, 1'b1, coin(), coin());
      repeat (ROM_BITS) send_request(CMD_PAIR, coin(), 1'b0, 1'b0);
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= CMD_NEW;
    in_ch.device_present  <= 1'b0;
    in_ch.bit_a           <= 1'b0;
    in_ch.bit_b           <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.search_command <= '0;
    clear_walk();
    command_byte = SEARCH_CMD_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_read_error();
    test_no_device();
    test_command_extremes();
    test_random_traffic(30, 62, 90, 8'($urandom));
    test_random_traffic(62, 30, 90, 8'hEC);
    test_random_traffic(0, 0, 90, 8'($urandom));
    test_count_climb();

    wait_quiet();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
